// File: design/nlp_pkg.sv
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared types and constants for the next lexicographic permutation engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nlp_pkg;

    localparam int MAX_ELEMS_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 16;

    localparam int CFG_W = 5;
    localparam int POS_W = 4;
    localparam int OUT_W = 16;
    localparam int IN_W  = 16;

    localparam logic [CFG_W-1:0] COUNT_RESET = 5'd16;

    typedef enum logic
    {
        OP_LOAD    = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    typedef struct packed
    {
        logic             strobe;
        logic [POS_W-1:0] position;
        logic [OUT_W-1:0] value;
        logic             advanced;
        logic             last;
    } res_t;

endpackage

// File: design/nlp_store.sv
// ----------------------------------------------------------------------------
// nlp_store
// Element memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlp_store import nlp_pkg::*;
#(
    parameter int MAX_ELEMS   = MAX_ELEMS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int IDX_W      = $clog2(MAX_ELEMS)
)
(
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_addr,
    input  logic [VALUE_WIDTH-1:0] wr_data,
    input  logic [IDX_W-1:0]       rd_addr,
    output logic [VALUE_WIDTH-1:0] rd_data
);

    logic [VALUE_WIDTH-1:0] mem [MAX_ELEMS];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/nlp_ctrl.sv
// ----------------------------------------------------------------------------
// nlp_ctrl
// Sequencer for one advance: pivot scan, successor scan, swap, suffix
// reversal and emission; the two scans share one signed comparator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlp_ctrl import nlp_pkg::*;
#(
    parameter int MAX_ELEMS   = MAX_ELEMS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int IDX_W      = $clog2(MAX_ELEMS),
    localparam int CNT_W      = $clog2(MAX_ELEMS + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   go,
    input  logic [CNT_W-1:0]       cnt,
    output logic [IDX_W-1:0]       rd_addr,
    input  logic [VALUE_WIDTH-1:0] rd_data,
    output logic                   wr_en,
    output logic [IDX_W-1:0]       wr_addr,
    output logic [VALUE_WIDTH-1:0] wr_data,
    output logic                   busy,
    output res_t                   res
);

    typedef enum logic [10:0]
    {
        S_IDLE   = 11'b000_0000_0001,
        S_PLOAD  = 11'b000_0000_0010,
        S_PIV    = 11'b000_0000_0100,
        S_SUC    = 11'b000_0000_1000,
        S_SWP    = 11'b000_0001_0000,
        S_RSTART = 11'b000_0010_0000,
        S_RHI    = 11'b000_0100_0000,
        S_RWLO   = 11'b000_1000_0000,
        S_RWHI   = 11'b001_0000_0000,
        S_ESTART = 11'b010_0000_0000,
        S_EMIT   = 11'b100_0000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic [IDX_W-1:0]       p_reg, p_next;
    logic [IDX_W-1:0]       q_reg, q_next;
    logic [VALUE_WIDTH-1:0] cur_reg, cur_next;
    logic [VALUE_WIDTH-1:0] pv_reg, pv_next;
    logic                   adv_reg, adv_next;
    res_t                   res_reg, res_next;

    logic [IDX_W-1:0]       nm1;
    logic [IDX_W-1:0]       p_inc;
    logic [IDX_W-1:0]       q_dec;
    logic [VALUE_WIDTH-1:0] cmp_a, cmp_b;
    logic                   lt;

    assign nm1   = IDX_W'(n_reg - CNT_W'(1));
    assign p_inc = p_reg + IDX_W'(1);
    assign q_dec = q_reg - IDX_W'(1);

    // shared signed comparator
    assign cmp_a = (state_reg == S_PIV) ? rd_data : pv_reg;
    assign cmp_b = (state_reg == S_PIV) ? cur_reg : rd_data;
    assign lt    = $signed(cmp_a) < $signed(cmp_b);

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        cur_next   = cur_reg;
        pv_next    = pv_reg;
        adv_next   = adv_reg;
        res_next   = res_reg;
        res_next.strobe = 1'b0;
        rd_addr    = p_reg;
        wr_en      = 1'b0;
        wr_addr    = p_reg;
        wr_data    = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = IDX_W'(cnt - CNT_W'(1));
                if (go)
                begin
                    n_next     = cnt;
                    p_next     = IDX_W'(cnt - CNT_W'(1));
                    adv_next   = 1'b0;
                    state_next = S_PLOAD;
                end
            end
            S_PLOAD:
            begin
                cur_next   = rd_data;
                rd_addr    = p_reg - IDX_W'(1);
                p_next     = p_reg - IDX_W'(1);
                state_next = S_PIV;
            end
            S_PIV:
            begin
                if (lt)
                begin
                    pv_next    = rd_data;
                    rd_addr    = nm1;
                    q_next     = nm1;
                    state_next = S_SUC;
                end
                else if (p_reg == '0)
                begin
                    state_next = S_ESTART;
                end
                else
                begin
                    cur_next = rd_data;
                    rd_addr  = p_reg - IDX_W'(1);
                    p_next   = p_reg - IDX_W'(1);
                end
            end
            S_SUC:
            begin
                if (lt)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = p_reg;
                    wr_data    = rd_data;
                    state_next = S_SWP;
                end
                else
                begin
                    rd_addr = q_dec;
                    q_next  = q_dec;
                end
            end
            S_SWP:
            begin
                wr_en      = 1'b1;
                wr_addr    = q_reg;
                wr_data    = pv_reg;
                p_next     = p_inc;
                q_next     = nm1;
                adv_next   = 1'b1;
                state_next = S_RSTART;
            end
            S_RSTART:
            begin
                if (p_reg < q_reg)
                begin
                    rd_addr    = p_reg;
                    state_next = S_RHI;
                end
                else
                begin
                    state_next = S_ESTART;
                end
            end
            S_RHI:
            begin
                rd_addr    = q_reg;
                cur_next   = rd_data;
                state_next = S_RWLO;
            end
            S_RWLO:
            begin
                wr_en      = 1'b1;
                wr_addr    = p_reg;
                wr_data    = rd_data;
                state_next = S_RWHI;
            end
            S_RWHI:
            begin
                wr_en   = 1'b1;
                wr_addr = q_reg;
                wr_data = cur_reg;
                p_next  = p_inc;
                q_next  = q_dec;
                if (p_inc < q_dec)
                begin
                    rd_addr    = p_inc;
                    state_next = S_RHI;
                end
                else
                begin
                    state_next = S_ESTART;
                end
            end
            S_ESTART:
            begin
                rd_addr    = '0;
                p_next     = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                res_next.strobe   = 1'b1;
                res_next.position = POS_W'(p_reg);
                res_next.value    = OUT_W'(rd_data);
                res_next.advanced = adv_reg;
                res_next.last     = (p_reg == nm1);
                if (p_reg == nm1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_addr = p_inc;
                    p_next  = p_inc;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg             <= n_next;
        p_reg             <= p_next;
        q_reg             <= q_next;
        cur_reg           <= cur_next;
        pv_reg            <= pv_next;
        adv_reg           <= adv_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign res  = res_reg;

endmodule

// File: design/next_lexicographic_permutation.sv
// ----------------------------------------------------------------------------
// next_lexicographic_permutation
// Holds a small array of signed elements and steps its first elem_count
// elements to the next lexicographic permutation on request.
//
// A load word (opcode 0) writes one element; busy stays low. An advance
// word (opcode 1) raises busy and, for n = the clamped element count, runs
// a pivot scan, a successor scan, a swap and a suffix reversal that swaps
// each element pair, then emits; with no ascent it goes from the pivot scan
// straight to emission. All steps go through the element memory, which
// serves one read and one write per cycle. The n result words follow one
// per cycle on result_strobe, the last with last_of_run; the receiver
// cannot stall them. The user must see that elem_count is written only
// while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module next_lexicographic_permutation import nlp_pkg::*;
#(
    parameter int MAX_ELEMS   = MAX_ELEMS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    opcode,
    input  logic [POS_W-1:0]        elem_index,
    input  logic signed [IN_W-1:0]  elem_value,
    input  logic                    cfg_we,
    input  logic [CFG_W-1:0]        cfg_wdata,
    output logic                    result_strobe,
    output logic [POS_W-1:0]        out_position,
    output logic signed [OUT_W-1:0] out_value,
    output logic                    advanced,
    output logic                    last_of_run
);

    localparam int IDX_W = $clog2(MAX_ELEMS);
    localparam int CNT_W = $clog2(MAX_ELEMS + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0]       elem_count_reg;
    logic [CMP_W-1:0]       count_ext;
    logic [CNT_W-1:0]       cnt;
    logic                   accept;
    logic                   load_ok;
    logic                   go;

    logic [IDX_W-1:0]       rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic                   ctl_wr_en;
    logic [IDX_W-1:0]       ctl_wr_addr;
    logic [VALUE_WIDTH-1:0] ctl_wr_data;
    logic                   mem_wr_en;
    logic [IDX_W-1:0]       mem_wr_addr;
    logic [VALUE_WIDTH-1:0] mem_wr_data;
    res_t                   res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            elem_count_reg <= cfg_wdata;
        end
    end

    // clamp count to 2..MAX_ELEMS
    assign count_ext = CMP_W'(elem_count_reg);
    always_comb
    begin
        priority if (count_ext < CMP_W'(2))
        begin
            cnt = CNT_W'(2);
        end
        else if (count_ext > CMP_W'(MAX_ELEMS))
        begin
            cnt = CNT_W'(MAX_ELEMS);
        end
        else
        begin
            cnt = CNT_W'(count_ext);
        end
    end

    assign accept  = start && !busy;
    assign load_ok = ({{(32 - POS_W){1'b0}}, elem_index} < 32'(MAX_ELEMS));
    assign go      = accept && (op_t'(opcode) == OP_ADVANCE);

    // loads only land while the sequencer is idle
    assign mem_wr_en   = ctl_wr_en || (accept && (op_t'(opcode) == OP_LOAD) && load_ok);
    assign mem_wr_addr = ctl_wr_en ? ctl_wr_addr : IDX_W'(elem_index);
    assign mem_wr_data = ctl_wr_en ? ctl_wr_data : VALUE_WIDTH'(elem_value);

    nlp_store #(
        .MAX_ELEMS   (MAX_ELEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    nlp_ctrl #(
        .MAX_ELEMS   (MAX_ELEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .cnt     (cnt),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (ctl_wr_en),
        .wr_addr (ctl_wr_addr),
        .wr_data (ctl_wr_data),
        .busy    (busy),
        .res     (res)
    );

    assign result_strobe = res.strobe;
    assign out_position  = res.position;
    assign out_value     = res.value;
    assign advanced      = res.advanced;
    assign last_of_run   = res.last;

    // an accepted advance word keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        go |=> busy)
        else $error("advance accepted but block not busy");

    // result words only come out of a running advance
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result word without a running advance");

    // a run is emitted without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last_of_run) |=> result_strobe)
        else $error("gap inside a result run");

    // nothing follows the last word of a run in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last_of_run) |=> !result_strobe)
        else $error("result word after end of run");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for next_lexicographic_permutation. Element loads and
// advance commands are sent through the start/busy handshake with random
// gaps. A behavioral model of the array predicts every result word of each
// advance, and a checker compares each strobed word field by field. The
// element count is rewritten between phases, covering the clamped values
// below and above the legal range.
// ----------------------------------------------------------------------------

module testbench;
    import nlp_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int CFG_SETTLE    = 8;
    localparam int END_SETTLE    = 128;
    localparam int RANDOM_WORDS  = 280;

    typedef struct {
        logic [POS_W-1:0]        position;
        logic signed [OUT_W-1:0] value;
        logic                    advanced;
        logic                    last;
    } perm_word_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    op_t                     opcode = OP_LOAD;
    logic [POS_W-1:0]        elem_index = '0;
    logic signed [IN_W-1:0]  elem_value = '0;
    logic                    cfg_we = 1'b0;
    logic [CFG_W-1:0]        cfg_wdata = '0;
    logic                    result_strobe;
    logic [POS_W-1:0]        out_position;
    logic signed [OUT_W-1:0] out_value;
    logic                    advanced;
    logic                    last_of_run;

    logic signed [IN_W-1:0]  perm_store [MAX_ELEMS_DEF];
    logic [CFG_W-1:0]        count_shadow = COUNT_RESET;
    perm_word_t              expected_words [$];
    perm_word_t              want;
    int                      error_count = 0;
    int                      cycle_count = 0;

    next_lexicographic_permutation dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .elem_index    (elem_index),
        .elem_value    (elem_value),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .result_strobe (result_strobe),
        .out_position  (out_position),
        .out_value     (out_value),
        .advanced      (advanced),
        .last_of_run   (last_of_run)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // result word checker
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: position %0d value %0d",
                       out_position, out_value);
                error_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (out_position !== want.position)
                begin
                    $error("out_position: expected %0d, got %0d", want.position, out_position);
                    error_count++;
                end
                if (out_value !== want.value)
                begin
                    $error("out_value: expected %0d, got %0d", want.value, out_value);
                    error_count++;
                end
                if (advanced !== want.advanced)
                begin
                    $error("advanced: expected %0d, got %0d", want.advanced, advanced);
                    error_count++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
                    error_count++;
                end
            end
        end
    end

    function automatic void swap_entries(int a, int b);
        logic signed [IN_W-1:0] t;
        t = perm_store[a];
        perm_store[a] = perm_store[b];
        perm_store[b] = t;
    endfunction

    // steps the shadow array and queues the words of one advance
    function automatic void step_permutation();
        int n;
        int p;
        int q;
        int lo;
        int hi;
        logic moved;
        n = count_shadow;
        if (n < 2)
            n = 2;
        if (n > MAX_ELEMS_DEF)
            n = MAX_ELEMS_DEF;
        moved = 1'b1;
        p = n - 1;
        while (perm_store[p-1] >= perm_store[p])
        begin
            p--;
            if (p == 0)
            begin
                moved = 1'b0;
                break;
            end
        end
        if (moved)
        begin
            q = n - 1;
            while (q > p && perm_store[q] <= perm_store[p-1])
                q--;
            swap_entries(p - 1, q);
            lo = p;
            hi = n - 1;
            while (lo < hi)
            begin
                swap_entries(lo, hi);
                lo++;
                hi--;
            end
        end
        for (int k = 0; k < n; k++)
            expected_words.push_back('{position: POS_W'(k), value: perm_store[k],
                                       advanced: moved, last: (k == n - 1)});
    endfunction

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic send_word(op_t op, logic [POS_W-1:0] idx, logic signed [IN_W-1:0] val);
        start      <= 1'b1;
        opcode     <= op;
        elem_index <= idx;
        elem_value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op == OP_LOAD)
            perm_store[idx] = val;
        else
            step_permutation();
    endtask

    // start low for a while, with junk on the word fields
    task automatic pause_words(int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles)
            begin
                opcode     <= op_t'($urandom_range(0, 1));
                elem_index <= POS_W'($urandom);
                elem_value <= IN_W'($urandom);
                @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained(int settle);
        start <= 1'b0;
        while (expected_words.size() != 0 || busy)
            @(posedge clk);
        repeat (settle)
            @(posedge clk);
    endtask

    task automatic write_elem_count(logic [CFG_W-1:0] v);
        wait_drained(CFG_SETTLE);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we       <= 1'b0;
        count_shadow = v;
    endtask

    task automatic send_advance();
        send_word(OP_ADVANCE, POS_W'($urandom), IN_W'($urandom));
    endtask

    task automatic test_directed();
        logic signed [IN_W-1:0] seed_values [MAX_ELEMS_DEF];
        seed_values = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1, 16'sd1, 16'sd5, 16'sd5,
                        -16'sd7, 16'sd3, 16'sd3, 16'sh5555, 16'shaaaa, 16'sd100,
                        16'sd9, 16'sd2, 16'sd1};
        for (int k = 0; k < MAX_ELEMS_DEF; k++)
        begin
            send_word(OP_LOAD, POS_W'(k), seed_values[k]);
            pause_words(random_gap());
        end
        send_advance();

        // pair: one ascent, then none
        write_elem_count(5'd2);
        send_word(OP_LOAD, 4'd0, 16'sh8000);
        send_word(OP_LOAD, 4'd1, 16'sh7fff);
        send_advance();
        pause_words(random_gap());
        send_advance();

        // descending pair is no ascent
        send_word(OP_LOAD, 4'd1, 16'sh8000);
        send_advance();

        // counts outside the legal range are clamped
        write_elem_count(5'd0);
        send_advance();
        write_elem_count(5'd1);
        send_advance();
        write_elem_count(5'd31);
        send_advance();
        write_elem_count(5'd17);
        send_advance();
    endtask

    task automatic test_random();
        int round_no;
        int used;
        int r;
        int cnt;
        int span;
        int loads;
        int steps;
        int tmp;
        logic no_gaps;
        logic narrow;
        round_no = 0;
        used = 0;
        while (used < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (round_no == 0)
                cnt = 2;
            else if (round_no == 1)
                cnt = 16;
            else if (r < 65)
                cnt = $urandom_range(2, 6);
            else if (r < 90)
                cnt = $urandom_range(7, 16);
            else
                cnt = $urandom_range(0, 31);
            write_elem_count(CFG_W'(cnt));
            span = (cnt < 2) ? 2 : ((cnt > 16) ? 16 : cnt);
            no_gaps = ($urandom_range(0, 3) == 0);
            narrow  = ($urandom_range(0, 2) != 0);

            loads = $urandom_range(0, span);
            repeat (loads)
            begin
                tmp = narrow ? ($urandom_range(0, 4) - 2) : $urandom;
                if ($urandom_range(0, 4) == 0)
                    send_word(OP_LOAD, POS_W'($urandom), IN_W'(tmp));
                else
                    send_word(OP_LOAD, POS_W'($urandom_range(0, span - 1)), IN_W'(tmp));
                used++;
                if (!no_gaps)
                    pause_words(random_gap());
            end

            steps = (span <= 4) ? $urandom_range(1, 8) : $urandom_range(1, 5);
            repeat (steps)
            begin
                // stray load in the middle of a walk
                if ($urandom_range(0, 5) == 0)
                begin
                    send_word(OP_LOAD, POS_W'($urandom), IN_W'($urandom));
                    used++;
                end
                send_advance();
                used++;
                if (!no_gaps)
                    pause_words(random_gap());
            end
            round_no++;
        end
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        wait_drained(END_SETTLE);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: files.f
design/nlp_pkg.sv
design/nlp_store.sv
design/nlp_ctrl.sv
design/next_lexicographic_permutation.sv
tb/testbench.sv
